>>> hw/rtl/rgbbt_pkg.sv
// Shared types, constants and a helper function for the RGB565 brightness/tint block.
package rgbbt_pkg;

  localparam int PIX_W   = 16;
  localparam int CH_W    = 8;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 8;
  localparam int AMT_W   = 7;   // blend amount 0..100
  localparam int PROD_W  = 15;  // up to 255 * 100

  localparam logic [7:0]        STEP_MAX    = 8'd200;
  localparam logic [7:0]        STEP_NEUTRAL = 8'd100;
  localparam logic signed [7:0] TINT_MAX    = 8'sd100;
  localparam logic signed [7:0] TINT_MIN    = -8'sd100;
  localparam logic [7:0]        CH_FULL     = 8'd255;

  // floor(x / 100) for x below 2^15 via reciprocal multiply
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int          RECIP_SH  = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BRIGHTNESS = 8'd0,
    CFG_TINT_RED   = 8'd1,
    CFG_TINT_GREEN = 8'd2,
    CFG_TINT_BLUE  = 8'd3
  } cfg_idx_t;

  typedef struct packed {
    logic             dark;    // blend toward black
    logic [AMT_W-1:0] amount;  // percent of the way to the target
  } chan_ctl_t;

  function automatic logic [CH_W-1:0] div100(input logic [PROD_W-1:0] x);
    logic [PROD_W+12:0] p;
    p = {13'd0, x} * {{PROD_W{1'b0}}, RECIP_100};
    return p[RECIP_SH+CH_W-1:RECIP_SH];
  endfunction

endpackage

>>> hw/rtl/rgbbt_ifs.sv
// Handshake interfaces for the pixel streams and the configuration write port.
interface rgbbt_pix_in_if;
  import rgbbt_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface rgbbt_pix_out_if;
  import rgbbt_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  modport source (output valid, output pixel_out, input ready);
  modport sink   (input valid, input pixel_out, output ready);
endinterface

interface rgbbt_cfg_if;
  import rgbbt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/rgbbt_step.sv
// Per-channel step unit: turns brightness and tint into a registered blend control.
module rgbbt_step
  import rgbbt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CH_W-1:0]      brightness,
  input  logic signed [CH_W-1:0] tint,
  output chan_ctl_t            ctl
);

  logic              pos;
  logic [AMT_W-1:0]  mag;
  logic [CH_W-1:0]   base;
  logic signed [CH_W-1:0] neg_tint;
  logic [PROD_W-1:0] prod_next;

  logic              prod_pos;
  logic [CH_W-1:0]   prod_b;
  logic [PROD_W-1:0] prod;

  logic [CH_W-1:0]   q;
  logic [CH_W-1:0]   step;
  chan_ctl_t         ctl_next;

  always_comb begin
    pos      = (tint > 8'sd0);
    neg_tint = -tint;
    mag      = pos ? tint[AMT_W-1:0] : neg_tint[AMT_W-1:0];
    base     = pos ? (STEP_MAX - brightness) : brightness;
    prod_next = PROD_W'({7'd0, base} * {8'd0, mag});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_pos <= 1'b0;
      prod_b   <= STEP_NEUTRAL;
      prod     <= '0;
    end else begin
      prod_pos <= pos;
      prod_b   <= brightness;
      prod     <= prod_next;
    end
  end

  always_comb begin
    q    = div100(prod);
    step = prod_pos ? (prod_b + q) : (prod_b - q);
    ctl_next.dark = (step < STEP_NEUTRAL);
    if (ctl_next.dark) begin
      ctl_next.amount = AMT_W'(STEP_NEUTRAL - step);
    end else begin
      ctl_next.amount = AMT_W'(step - STEP_NEUTRAL);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_next;
    end
  end

endmodule

>>> hw/rtl/rgb565_brightness_tint_core.sv
// Top level: RGB565 brightness and per-channel tint, one pixel per cycle unless stalled.
//
// Channels: pix_in takes RGB565 pixels, pix_out returns the adjusted pixels,
// cfg writes the four settings (0 brightness step, 1..3 red/green/blue tint).
// Brightness above 200 is stored as 200; tints clamp to -100..100.
// Throughput is one pixel per cycle while the output is not stalled and no
// config write is settling; an input beat passes a product stage, then the
// divide-by-100 and repack into the output register.
// A config write retriggers the two-stage channel step pipeline; pix_in.ready
// stays low after the write while the steps settle.
// cfg.ready is always high.
// When pix_out stalls, the output register holds its beat and the product
// stage keeps one more pixel; pix_in.ready drops only once both are full.
// Reset (rst, synchronous) restores brightness 100 and zero tints, which is
// pass-through, and empties the pipeline. No clearing pass is needed.
module rgb565_brightness_tint_core
  import rgbbt_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  rgbbt_pix_in_if.sink    pix_in,
  rgbbt_pix_out_if.source pix_out,
  rgbbt_cfg_if.sink       cfg
);

  logic [CH_W-1:0]        brightness;
  logic signed [CH_W-1:0] tint [3];
  chan_ctl_t              ctl [3];
  logic [1:0]             settle;

  logic cfg_wr;
  logic signed [CH_W-1:0] tint_clamped;
  logic out_adv;
  logic s1_adv;
  logic in_acc;

  logic                 s1_valid;
  logic [PIX_W-1:0]     s1_pixel;
  logic                 s1_neutral;
  logic [CH_W-1:0]      s1_v8 [3];
  logic                 s1_dark [3];
  logic [PROD_W-1:0]    s1_prod [3];

  logic [CH_W-1:0]      v8 [3];
  logic [PROD_W-1:0]    prod_next [3];
  logic [CH_W-1:0]      res8 [3];
  logic [5:0]           r5_raw;
  logic [6:0]           g6_raw;
  logic [5:0]           b5_raw;
  logic [PIX_W-1:0]     pixel_next;

  logic                 out_valid;
  logic [PIX_W-1:0]     out_pixel;

  // configuration
  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid;

  always_comb begin
    if ($signed(cfg.data) > TINT_MAX) begin
      tint_clamped = TINT_MAX;
    end else if ($signed(cfg.data) < TINT_MIN) begin
      tint_clamped = TINT_MIN;
    end else begin
      tint_clamped = $signed(cfg.data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= STEP_NEUTRAL;
      tint[0]    <= '0;
      tint[1]    <= '0;
      tint[2]    <= '0;
      settle     <= '0;
    end else begin
      if (cfg_wr) begin
        settle <= 2'd2;
        unique case (cfg.index)
          CFG_BRIGHTNESS: brightness <= (cfg.data > STEP_MAX) ? STEP_MAX : cfg.data;
          CFG_TINT_RED:   tint[0] <= tint_clamped;
          CFG_TINT_GREEN: tint[1] <= tint_clamped;
          CFG_TINT_BLUE:  tint[2] <= tint_clamped;
          default: ;
        endcase
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_step
    rgbbt_step u_step (
      .clk        (clk),
      .rst        (rst),
      .brightness (brightness),
      .tint       (tint[c]),
      .ctl        (ctl[c])
    );
  end

  // handshake
  assign out_adv      = !out_valid || pix_out.ready;
  assign s1_adv       = !s1_valid || out_adv;
  assign pix_in.ready = (settle == 2'd0) && s1_adv;
  assign in_acc       = pix_in.valid && pix_in.ready;

  // stage 1: widen and form blend products
  always_comb begin
    v8[0] = {pix_in.pixel_in[15:11], pix_in.pixel_in[15:13]};
    v8[1] = {pix_in.pixel_in[10:5],  pix_in.pixel_in[10:9]};
    v8[2] = {pix_in.pixel_in[4:0],   pix_in.pixel_in[4:2]};
    for (int c = 0; c < 3; c++) begin
      if (ctl[c].dark) begin
        prod_next[c] = PROD_W'({7'd0, v8[c]} * {8'd0, ctl[c].amount});
      end else begin
        prod_next[c] = PROD_W'({7'd0, CH_FULL - v8[c]} * {8'd0, ctl[c].amount});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= in_acc;
    end
    if (in_acc) begin
      s1_pixel   <= pix_in.pixel_in;
      s1_neutral <= (ctl[0].amount == '0) && (ctl[1].amount == '0) &&
                    (ctl[2].amount == '0);
      for (int c = 0; c < 3; c++) begin
        s1_v8[c]   <= v8[c];
        s1_dark[c] <= ctl[c].dark;
        s1_prod[c] <= prod_next[c];
      end
    end
  end

  // stage 2: divide by 100, blend, repack with rounding and saturation; neutral pixels pass unchanged
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      res8[c] = s1_dark[c] ? (s1_v8[c] - div100(s1_prod[c]))
                           : (s1_v8[c] + div100(s1_prod[c]));
    end
    r5_raw = 6'(({1'b0, res8[0]} + 9'd4) >> 3);
    g6_raw = 7'(({1'b0, res8[1]} + 9'd2) >> 2);
    b5_raw = 6'(({1'b0, res8[2]} + 9'd4) >> 3);
    if (s1_neutral) begin
      pixel_next = s1_pixel;
    end else begin
      pixel_next[15:11] = r5_raw[5] ? 5'h1F : r5_raw[4:0];
      pixel_next[10:5]  = g6_raw[6] ? 6'h3F : g6_raw[5:0];
      pixel_next[4:0]   = b5_raw[5] ? 5'h1F : b5_raw[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
    if (out_adv && s1_valid) begin
      out_pixel <= pixel_next;
    end
  end

  assign pix_out.valid     = out_valid;
  assign pix_out.pixel_out = out_pixel;

endmodule

>>> hw/rtl/rgbbt_checker.sv
// Port-level checks for the brightness/tint core, attached by bind.
module rgbbt_checker
  import rgbbt_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] out_pixel,
  input logic             cfg_valid,
  input logic             cfg_ready
);

  // a stalled output beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  // channel steps are recomputing right after a config write
  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input taken while channel steps settle");

  // the output register is occupied once an accepted pixel has passed the product stage
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("output empty two cycles after an accepted pixel");

  // a full output register with a full product stage blocks the input
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && $past(out_valid && !out_ready) && $past(in_valid && in_ready)
      |-> !in_ready)
    else $error("input accepted with pipeline full");

  // stalled payload keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_pixel))
    else $error("output pixel changed while stalled");

endmodule

bind rgb565_brightness_tint_core rgbbt_checker u_rgbbt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix_in.valid),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .out_pixel (pix_out.pixel_out),
  .cfg_valid (cfg.valid),
  .cfg_ready (cfg.ready)
);

>>> sim/tb_top.sv
// Self-checking testbench for the RGB565 brightness/tint core: directed and random pixels.
`timescale 1ns / 100ps

module tb_top;
  import rgbbt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 300;
  localparam int ITEMS_PER_SET = 25;
  localparam int SETS_PER_PHASE = 6;
  localparam int DRAIN_CYCLES = 6;
  localparam int CH_R = 0;
  localparam int CH_G = 1;
  localparam int CH_B = 2;
  localparam logic [7:0] IDX_UNUSED_LO = 8'd4;
  localparam logic [7:0] IDX_UNUSED_HI = 8'hFF;
  localparam logic [15:0] PIX_SET_A [5] = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F};
  localparam logic [15:0] PIX_SET_B [5] = '{16'h8410, 16'h7BEF, 16'h0821, 16'hAAAA, 16'h5555};
  localparam int SRC_IDLE_TAB [4] = '{0, 79, 0, 23};
  localparam int RX_STALL_TAB [4] = '{0, 0, 79, 23};

  typedef struct {
    logic [PIX_W-1:0] src;
    logic [PIX_W-1:0] want;
  } pix_check_t;

  logic clk;
  logic rst;

  rgbbt_pix_in_if  pix_in_bus ();
  rgbbt_pix_out_if pix_out_bus ();
  rgbbt_cfg_if     cfg_bus ();

  rgb565_brightness_tint_core dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in_bus),
    .pix_out (pix_out_bus),
    .cfg     (cfg_bus)
  );

  // mirror of the programmed settings
  logic [7:0] bright_q;
  int tint_q [3];

  logic [PIX_W-1:0] pix_q [$];
  pix_check_t adjusted_q [$];
  pix_check_t drv_chk;
  pix_check_t mon_chk;

  int src_idle_pct;
  int rx_stall_pct;
  int err_count;
  int cycle_count;
  bit hold_arm;
  bit hold_done;
  int hold_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int tint_clamp(logic [7:0] raw);
    int t;
    t = int'($signed(raw));
    if (t > 100) t = 100;
    if (t < -100) t = -100;
    return t;
  endfunction

  function automatic int chan_step(int tint);
    int b;
    b = int'(bright_q);
    if (tint > 0) return b + (200 - b) * tint / 100;
    return b + b * tint / 100;
  endfunction

  function automatic logic [7:0] fade_chan(logic [7:0] v8, int stp);
    int v, tgt, amt, r;
    v = int'(v8);
    if (stp < 100) begin
      tgt = 0;
      amt = 100 - stp;
    end else begin
      tgt = 255;
      amt = stp - 100;
    end
    r = v + (tgt - v) * amt / 100;
    if (r < 0) r = 0;
    if (r > 255) r = 255;
    return r[7:0];
  endfunction

  function automatic logic [PIX_W-1:0] adjust_pixel(logic [PIX_W-1:0] px);
    int sr, sg, sb, rr, gg, bb;
    logic [4:0] r5, b5;
    logic [5:0] g6;
    logic [7:0] r8, g8, b8;
    sr = chan_step(tint_q[CH_R]);
    sg = chan_step(tint_q[CH_G]);
    sb = chan_step(tint_q[CH_B]);
    if (sr == 100 && sg == 100 && sb == 100) return px;
    r5 = px[15:11];
    g6 = px[10:5];
    b5 = px[4:0];
    r8 = fade_chan({r5, r5[4:2]}, sr);
    g8 = fade_chan({g6, g6[5:4]}, sg);
    b8 = fade_chan({b5, b5[4:2]}, sb);
    rr = (int'(r8) + 4) >> 3;
    gg = (int'(g8) + 2) >> 2;
    bb = (int'(b8) + 4) >> 3;
    if (rr > 31) rr = 31;
    if (gg > 63) gg = 63;
    if (bb > 31) bb = 31;
    return {rr[4:0], gg[5:0], bb[4:0]};
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [4:0] r5, b5;
    logic [5:0] g6;
    if ($urandom_range(0, 4) != 0) return PIX_W'($urandom);
    // channels pinned at zero or full scale
    r5 = $urandom_range(0, 1) ? 5'h1F : 5'h00;
    g6 = $urandom_range(0, 1) ? 6'h3F : 6'h00;
    b5 = $urandom_range(0, 1) ? 5'h1F : 5'h00;
    return {r5, g6, b5};
  endfunction

  function automatic logic [7:0] rand_bright();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return STEP_MAX;
      2: return STEP_NEUTRAL;
      3: return 8'hFF;
      4: return 8'(201);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] rand_tint();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'h64;  // +100
      2: return 8'h9C;  // -100
      3: return 8'h7F;
      4: return 8'h80;
      5: return 8'h32;  // +50
      6: return 8'hCE;  // -50
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_BRIGHTNESS: bright_q = (val > STEP_MAX) ? STEP_MAX : val;
      CFG_TINT_RED:   tint_q[CH_R] = tint_clamp(val);
      CFG_TINT_GREEN: tint_q[CH_G] = tint_clamp(val);
      CFG_TINT_BLUE:  tint_q[CH_B] = tint_clamp(val);
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pix_q.size() != 0 || adjusted_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic directed_set(input logic [7:0] b, input logic [7:0] tr,
                              input logic [7:0] tg, input logic [7:0] tb,
                              input bit alt);
    write_reg(CFG_BRIGHTNESS, b);
    write_reg(CFG_TINT_RED, tr);
    write_reg(CFG_TINT_GREEN, tg);
    write_reg(CFG_TINT_BLUE, tb);
    for (int i = 0; i < 5; i++) pix_q.push_back(alt ? PIX_SET_B[i] : PIX_SET_A[i]);
    wait_drain();
  endtask

  task automatic random_config(input bit write_all);
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      write_reg(CFG_BRIGHTNESS, STEP_NEUTRAL);
      write_reg(CFG_TINT_RED, 8'h00);
      write_reg(CFG_TINT_GREEN, 8'h00);
      write_reg(CFG_TINT_BLUE, 8'h00);
    end else begin
      if (write_all || $urandom_range(0, 4) != 0) write_reg(CFG_BRIGHTNESS, rand_bright());
      if (write_all || $urandom_range(0, 4) != 0) write_reg(CFG_TINT_RED, rand_tint());
      if (write_all || $urandom_range(0, 4) != 0) write_reg(CFG_TINT_GREEN, rand_tint());
      if (write_all || $urandom_range(0, 4) != 0) write_reg(CFG_TINT_BLUE, rand_tint());
      if (pick == 1) write_reg($urandom_range(0, 1) ? IDX_UNUSED_HI : IDX_UNUSED_LO,
                               8'($urandom_range(0, 255)));
    end
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      pix_in_bus.valid <= 1'b0;
    end else begin
      if (pix_in_bus.valid && pix_in_bus.ready) begin
        drv_chk.src  = pix_in_bus.pixel_in;
        drv_chk.want = adjust_pixel(pix_in_bus.pixel_in);
        adjusted_q.push_back(drv_chk);
        void'(pix_q.pop_front());
      end
      // an offered beat stays up until taken
      if (!pix_in_bus.valid || pix_in_bus.ready) begin
        if (pix_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          pix_in_bus.valid    <= 1'b1;
          pix_in_bus.pixel_in <= pix_q[0];
        end else begin
          pix_in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold, armed once from the stimulus
  always @(posedge clk) begin
    if (hold_arm && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt  <= LONG_HOLD;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // result monitor and receiver backpressure
  always @(posedge clk) begin
    if (rst) begin
      pix_out_bus.ready <= 1'b0;
    end else begin
      if (pix_out_bus.valid && pix_out_bus.ready) begin
        if (adjusted_q.size() == 0) begin
          $display("%0t: unexpected pixel beat, expected none, got %h",
                   $time, pix_out_bus.pixel_out);
          err_count++;
        end else begin
          mon_chk = adjusted_q.pop_front();
          if (pix_out_bus.pixel_out !== mon_chk.want) begin
            $display("%0t: pixel_out mismatch for input %h: expected %h, got %h",
                     $time, mon_chk.src, mon_chk.want, pix_out_bus.pixel_out);
            err_count++;
          end
        end
      end
      if (hold_cnt != 0 || (hold_arm && !hold_done)) begin
        pix_out_bus.ready <= 1'b0;
      end else begin
        pix_out_bus.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d pixels pending, %0d results outstanding",
               $time, pix_q.size(), adjusted_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    pix_in_bus.valid = 1'b0;
    pix_in_bus.pixel_in = '0;
    pix_out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    bright_q = STEP_NEUTRAL;
    tint_q = '{0, 0, 0};
    src_idle_pct = 0;
    rx_stall_pct = 0;
    err_count = 0;
    cycle_count = 0;
    hold_arm = 1'b0;
    hold_done = 1'b0;
    hold_cnt = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // after reset: pass-through
    for (int i = 0; i < 5; i++) pix_q.push_back(PIX_SET_A[i]);
    wait_drain();
    // out-of-range writes saturate: red to white, green to black, blue to white
    directed_set(8'hFF, 8'h7F, 8'h80, 8'h65, 1'b1);
    // zero base with +50 tint lands on neutral red; unused indexes are ignored
    write_reg(IDX_UNUSED_LO, 8'h00);
    write_reg(IDX_UNUSED_HI, 8'h00);
    directed_set(8'h00, 8'h32, 8'h9B, 8'h64, 1'b0);
    // only red off neutral: green and blue take the round trip and may drift
    directed_set(STEP_NEUTRAL, 8'h32, 8'h00, 8'h00, 1'b1);
    // full base pulled back by -50 on every channel is neutral again
    directed_set(STEP_MAX, 8'hCE, 8'hCE, 8'hCE, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = SRC_IDLE_TAB[ph];
      rx_stall_pct = RX_STALL_TAB[ph];
      for (int k = 0; k < SETS_PER_PHASE; k++) begin
        random_config(k == 0);
        if (k == 2) begin
          // sender pauses mid-set until everything is back
          for (int i = 0; i < ITEMS_PER_SET / 2; i++) pix_q.push_back(rand_pixel());
          wait_drain();
          for (int i = ITEMS_PER_SET / 2; i < ITEMS_PER_SET; i++) pix_q.push_back(rand_pixel());
        end else begin
          for (int i = 0; i < ITEMS_PER_SET; i++) pix_q.push_back(rand_pixel());
        end
        if (ph == 0 && k == 1) hold_arm = 1'b1;
        wait_drain();
      end
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
